>>> rtl/duid_pkg.sv
// Shared widths, operation codes and status codes for the device identifier table.
package duid_pkg;

	// Field widths.
	localparam int OP_W     = 3;
	localparam int UID_W    = 48;
	localparam int IDX_W    = 7;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = 8;

	// Default number of table entries.
	localparam int DEFAULT_DEPTH = 128;

	// Value that marks a free slot.
	localparam logic [UID_W-1:0] UID_ONES = '1;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OP_W-1:0] OP_DEL    = 3'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
	localparam logic [OP_W-1:0] OP_READ   = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DUP       = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

endpackage

>>> rtl/duid_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module duid_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write first port, registered read on the second.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/device_uid_table_top.sv
// Top level of the device identifier table: sequencer around one table RAM.
//
// The block takes one request at a time: a request is taken when start is high and busy is
// low, and busy stays high until the result is ready. The result appears on ok, status,
// uid_out and count for exactly one cycle with done high, in the same cycle that busy falls;
// the receiver must take it then. Every search walks the table RAM one entry at a time, reading
// each entry in S_SRCH and comparing it in S_CMP, and a delete then moves each later entry
// down, reading in S_SH_RD and writing in S_SH_WR. Slots at or beyond the entry count are
// never read, so clear only resets the count and no clearing pass is needed after reset.
module device_uid_table_top #(
	parameter int TABLE_DEPTH = duid_pkg::DEFAULT_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [duid_pkg::OP_W-1:0]     op,
	input  logic [duid_pkg::UID_W-1:0]    uid,
	input  logic [duid_pkg::IDX_W-1:0]    index,
	output logic                          done,
	output logic                          ok,
	output logic [duid_pkg::STATUS_W-1:0] status,
	output logic [duid_pkg::UID_W-1:0]    uid_out,
	output logic [duid_pkg::CNT_W-1:0]    count
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [duid_pkg::CNT_W-1:0] DEPTH_C = duid_pkg::CNT_W'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SRCH,
		S_CMP,
		S_SH_RD,
		S_SH_WR,
		S_RD_WAIT
	} state_t;

	state_t                        state_q;
	logic [duid_pkg::OP_W-1:0]     op_q;
	logic [duid_pkg::UID_W-1:0]    uid_q;
	logic [duid_pkg::IDX_W-1:0]    index_q;
	logic [duid_pkg::CNT_W-1:0]    count_q;
	logic [duid_pkg::CNT_W-1:0]    ptr_q;
	logic                          done_q;
	logic                          ok_q;
	logic [duid_pkg::STATUS_W-1:0] status_q;
	logic [duid_pkg::UID_W-1:0]    uid_out_q;
	logic [duid_pkg::CNT_W-1:0]    count_out_q;

	logic [duid_pkg::CNT_W-1:0]    idx_ext;
	logic [duid_pkg::CNT_W-1:0]    ptr_inc;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [AW-1:0]                 ram_raddr;
	logic [duid_pkg::UID_W-1:0]    ram_wdata;
	logic [duid_pkg::UID_W-1:0]    ram_rdata;

	assign idx_ext = duid_pkg::CNT_W'(index_q);
	assign ptr_inc = ptr_q + duid_pkg::CNT_W'(1);

	// Table storage.
	duid_ram #(
		.WIDTH(duid_pkg::UID_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// RAM address and write control for each sequencer step.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = ptr_q[AW-1:0];
		case (state_q)
			S_DECIDE: begin
				ram_raddr = idx_ext[AW-1:0];
			end
			S_SRCH: begin
				// Search ran past the last entry: an add appends at the count.
				if (ptr_q >= count_q && op_q == duid_pkg::OP_ADD) begin
					ram_we    = 1'b1;
					ram_waddr = count_q[AW-1:0];
					ram_wdata = uid_q;
				end
			end
			S_SH_RD: begin
				ram_raddr = ptr_inc[AW-1:0];
				// Last slot of a delete gets the free-slot value.
				if (ptr_inc >= count_q) begin
					ram_we    = 1'b1;
					ram_wdata = duid_pkg::UID_ONES;
				end
			end
			S_SH_WR: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state, entry count and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= duid_pkg::OP_ADD;
			uid_q       <= '0;
			index_q     <= '0;
			count_q     <= '0;
			ptr_q       <= '0;
			done_q      <= 1'b0;
			ok_q        <= 1'b0;
			status_q    <= duid_pkg::ST_OK;
			uid_out_q   <= '0;
			count_out_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= op;
						uid_q   <= uid;
						index_q <= index;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					ptr_q <= '0;
					case (op_q)
						duid_pkg::OP_ADD: begin
							if (count_q >= DEPTH_C) begin
								done_q      <= 1'b1;
								ok_q        <= 1'b0;
								status_q    <= duid_pkg::ST_FULL;
								uid_out_q   <= '0;
								count_out_q <= count_q;
								state_q     <= S_IDLE;
							end else begin
								state_q <= S_SRCH;
							end
						end
						duid_pkg::OP_DEL, duid_pkg::OP_LOOKUP: begin
							state_q <= S_SRCH;
						end
						duid_pkg::OP_READ: begin
							if (idx_ext < count_q) begin
								state_q <= S_RD_WAIT;
							end else begin
								done_q      <= 1'b1;
								ok_q        <= 1'b0;
								status_q    <= duid_pkg::ST_RANGE;
								uid_out_q   <= '0;
								count_out_q <= count_q;
								state_q     <= S_IDLE;
							end
						end
						duid_pkg::OP_CLEAR: begin
							count_q     <= '0;
							done_q      <= 1'b1;
							ok_q        <= 1'b1;
							status_q    <= duid_pkg::ST_OK;
							uid_out_q   <= '0;
							count_out_q <= '0;
							state_q     <= S_IDLE;
						end
						default: begin
							done_q      <= 1'b1;
							ok_q        <= 1'b0;
							status_q    <= duid_pkg::ST_OK;
							uid_out_q   <= '0;
							count_out_q <= count_q;
							state_q     <= S_IDLE;
						end
					endcase
				end
				S_SRCH: begin
					if (ptr_q < count_q) begin
						state_q <= S_CMP;
					end else if (op_q == duid_pkg::OP_ADD) begin
						// Not present: the entry was appended this cycle.
						count_q     <= count_q + duid_pkg::CNT_W'(1);
						done_q      <= 1'b1;
						ok_q        <= 1'b1;
						status_q    <= duid_pkg::ST_OK;
						uid_out_q   <= '0;
						count_out_q <= count_q + duid_pkg::CNT_W'(1);
						state_q     <= S_IDLE;
					end else begin
						done_q      <= 1'b1;
						ok_q        <= 1'b0;
						status_q    <= duid_pkg::ST_NOT_FOUND;
						uid_out_q   <= '0;
						count_out_q <= count_q;
						state_q     <= S_IDLE;
					end
				end
				S_CMP: begin
					if (ram_rdata == uid_q) begin
						case (op_q)
							duid_pkg::OP_ADD: begin
								done_q      <= 1'b1;
								ok_q        <= 1'b0;
								status_q    <= duid_pkg::ST_DUP;
								uid_out_q   <= '0;
								count_out_q <= count_q;
								state_q     <= S_IDLE;
							end
							duid_pkg::OP_LOOKUP: begin
								done_q      <= 1'b1;
								ok_q        <= 1'b1;
								status_q    <= duid_pkg::ST_OK;
								uid_out_q   <= '0;
								count_out_q <= count_q;
								state_q     <= S_IDLE;
							end
							default: begin
								// Delete: compact from the matching slot onward.
								state_q <= S_SH_RD;
							end
						endcase
					end else begin
						ptr_q   <= ptr_inc;
						state_q <= S_SRCH;
					end
				end
				S_SH_RD: begin
					if (ptr_inc < count_q) begin
						state_q <= S_SH_WR;
					end else begin
						count_q     <= count_q - duid_pkg::CNT_W'(1);
						done_q      <= 1'b1;
						ok_q        <= 1'b1;
						status_q    <= duid_pkg::ST_OK;
						uid_out_q   <= '0;
						count_out_q <= count_q - duid_pkg::CNT_W'(1);
						state_q     <= S_IDLE;
					end
				end
				S_SH_WR: begin
					ptr_q   <= ptr_inc;
					state_q <= S_SH_RD;
				end
				S_RD_WAIT: begin
					done_q      <= 1'b1;
					ok_q        <= 1'b1;
					status_q    <= duid_pkg::ST_OK;
					uid_out_q   <= ram_rdata;
					count_out_q <= count_q;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Port drive.
	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign ok      = ok_q;
	assign status  = status_q;
	assign uid_out = uid_out_q;
	assign count   = count_out_q;

endmodule

>>> rtl/duid_checker.sv
// Port-level checks for the device identifier table, bound to the top level.
module duid_checker #(
	parameter int TABLE_DEPTH = duid_pkg::DEFAULT_DEPTH
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic                          ok,
	input logic [duid_pkg::STATUS_W-1:0] status,
	input logic [duid_pkg::UID_W-1:0]    uid_out,
	input logic [duid_pkg::CNT_W-1:0]    count
);

	localparam logic [duid_pkg::CNT_W-1:0] DEPTH_C = duid_pkg::CNT_W'(TABLE_DEPTH);

	// A taken request always keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after a request was taken");

	// A result is only shown once the block has finished its request.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	// The entry count never passes the table depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> count <= DEPTH_C)
		else $error("count above table depth");

	// A successful request reports the ok status.
	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && ok |-> status == duid_pkg::ST_OK)
		else $error("ok result with an error status");

	// A failed request returns no identifier.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> uid_out == '0)
		else $error("failed request returned an identifier");

endmodule

bind device_uid_table_top duid_checker #(
	.TABLE_DEPTH(TABLE_DEPTH)
) u_duid_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.ok     (ok),
	.status (status),
	.uid_out(uid_out),
	.count  (count)
);

>>> test/device_uid_table_top_tb.sv
`timescale 1ns / 1ps
// Testbench for the device identifier table: directed and random requests against a model.
module device_uid_table_top_tb;
	import duid_pkg::*;

	localparam int TBL_DEPTH    = DEFAULT_DEPTH;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int DRAIN_CYCLES = 2 * TBL_DEPTH + 16;

	// One result as the block reports it.
	typedef struct packed {
		logic                ok;
		logic [STATUS_W-1:0] status;
		logic [UID_W-1:0]    uid_out;
		logic [CNT_W-1:0]    count;
	} table_reply_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [OP_W-1:0]     op;
	logic [UID_W-1:0]    uid;
	logic [IDX_W-1:0]    index;
	logic                done;
	logic                ok;
	logic [STATUS_W-1:0] status;
	logic [UID_W-1:0]    uid_out;
	logic [CNT_W-1:0]    count;

	// Behavioral copy of the table and the replies it predicts.
	logic [UID_W-1:0] uid_table [TBL_DEPTH];
	int               table_count;
	table_reply_t     expected_replies [$];

	int mismatch_count;
	int cycle_count;
	bit gaps_on;

	device_uid_table_top #(
		.TABLE_DEPTH(TBL_DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.op     (op),
		.uid    (uid),
		.index  (index),
		.done   (done),
		.ok     (ok),
		.status (status),
		.uid_out(uid_out),
		.count  (count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Returns the position of the first valid entry equal to key, or -1.
	function automatic int find_entry(input logic [UID_W-1:0] key);
		for (int i = 0; i < table_count; i++) begin
			if (uid_table[i] == key)
				return i;
		end
		return -1;
	endfunction

	// Applies one accepted request to the table copy and queues the reply it should produce.
	function automatic void table_apply(input logic [OP_W-1:0] req_op,
			input logic [UID_W-1:0] req_uid, input logic [IDX_W-1:0] req_idx);
		table_reply_t reply;
		int pos;
		reply = '0;
		case (req_op)
			OP_ADD: begin
				if (table_count >= TBL_DEPTH) begin
					reply.status = ST_FULL;
				end else if (find_entry(req_uid) >= 0) begin
					reply.status = ST_DUP;
				end else begin
					uid_table[table_count] = req_uid;
					table_count++;
					reply.ok = 1'b1;
				end
			end
			OP_DEL: begin
				pos = find_entry(req_uid);
				if (pos < 0) begin
					reply.status = ST_NOT_FOUND;
				end else begin
					// Close the gap and free the last used slot.
					for (int i = pos; i + 1 < table_count; i++)
						uid_table[i] = uid_table[i + 1];
					uid_table[table_count - 1] = UID_ONES;
					table_count--;
					reply.ok = 1'b1;
				end
			end
			OP_LOOKUP: begin
				if (find_entry(req_uid) >= 0)
					reply.ok = 1'b1;
				else
					reply.status = ST_NOT_FOUND;
			end
			OP_READ: begin
				if (int'(req_idx) < table_count) begin
					reply.uid_out = uid_table[req_idx];
					reply.ok = 1'b1;
				end else begin
					reply.status = ST_RANGE;
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < table_count; i++)
					uid_table[i] = UID_ONES;
				table_count = 0;
				reply.ok = 1'b1;
			end
			default: begin
			end
		endcase
		reply.count = CNT_W'(table_count);
		expected_replies.push_back(reply);
	endfunction

	function automatic logic [UID_W-1:0] rand_uid();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return bits[UID_W-1:0];
	endfunction

	// Mostly back to back, some short pauses, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Picks an identifier: a present entry unless the table is empty or the roll falls below new_pct.
	function automatic logic [UID_W-1:0] pick_uid(input int new_pct);
		int r;
		r = $urandom_range(0, 99);
		if (table_count != 0 && r >= new_pct)
			return uid_table[$urandom_range(0, table_count - 1)];
		if (r < 5)
			return UID_ONES;
		if (r < 8)
			return '0;
		return rand_uid();
	endfunction

	function automatic logic [IDX_W-1:0] pick_index();
		if (table_count != 0 && $urandom_range(0, 99) < 70)
			return IDX_W'($urandom_range(0, table_count - 1));
		return IDX_W'($urandom_range(0, 2**IDX_W - 1));
	endfunction

	// Presents one request from a falling edge and holds it until the block takes it.
	// Returns at the falling edge after acceptance with start still high.
	task automatic send_request(input logic [OP_W-1:0] req_op,
			input logic [UID_W-1:0] req_uid, input logic [IDX_W-1:0] req_idx);
		int gap;
		bit taken;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		op    <= req_op;
		uid   <= req_uid;
		index <= req_idx;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
		table_apply(req_op, req_uid, req_idx);
		@(negedge clk);
	endtask

	task automatic flag_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("Mismatch on %s at %0d ns: expected 0x%0h, got 0x%0h",
				field, $time, want, got);
	endtask

	// Each result is compared with the oldest predicted reply.
	always @(posedge clk) begin : check_replies
		table_reply_t want;
		if (arst_n && done) begin
			if (expected_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Result with no request pending at %0d ns", $time);
			end else begin
				want = expected_replies.pop_front();
				if (ok !== want.ok)
					flag_mismatch("ok", 64'(want.ok), 64'(ok));
				if (status !== want.status)
					flag_mismatch("status", 64'(want.status), 64'(status));
				if (uid_out !== want.uid_out)
					flag_mismatch("uid_out", 64'(want.uid_out), 64'(uid_out));
				if (count !== want.count)
					flag_mismatch("count", 64'(want.count), 64'(count));
			end
		end
	end

	// Empty table: reads, searches and clear with nothing stored, and the unused codes.
	task automatic test_empty_table();
		send_request(OP_READ, '0, '0);
		send_request(OP_LOOKUP, '0, '0);
		send_request(OP_DEL, UID_ONES, '1);
		send_request(OP_CLEAR, UID_ONES, '1);
		send_request(3'd5, UID_ONES, '1);
		send_request(3'd6, '0, '0);
		send_request(3'd7, rand_uid(), '1);
	endtask

	// Every operation on a small table, with the extreme identifiers.
	task automatic test_basic_ops();
		send_request(OP_ADD, '0, '0);
		send_request(OP_ADD, UID_ONES, '0);
		send_request(OP_ADD, 48'h8000_0000_0001, '1);
		send_request(OP_ADD, UID_ONES, '0);
		send_request(OP_LOOKUP, UID_ONES, '0);
		send_request(OP_LOOKUP, 48'h8000_0000_0001, '0);
		send_request(OP_READ, '1, 7'd0);
		send_request(OP_READ, '0, 7'd2);
		send_request(OP_READ, '0, 7'd3);
		send_request(OP_READ, '0, 7'd127);
		send_request(OP_DEL, UID_ONES, '0);
		send_request(OP_READ, '0, 7'd1);
		send_request(OP_DEL, '0, '0);
		send_request(OP_LOOKUP, '0, '0);
		send_request(OP_READ, '0, 7'd0);
		send_request(OP_CLEAR, '0, '0);
		send_request(OP_READ, '0, 7'd0);
	endtask

	// Fill the table, then add, search and delete around the full boundary.
	task automatic test_full_table();
		logic [UID_W-1:0] fill_uid;
		logic [UID_W-1:0] first_uid;
		logic [UID_W-1:0] mid_uid;
		int i;
		for (i = 0; i < TBL_DEPTH; i++) begin
			// The low bits carry the slot number, so every identifier is distinct.
			fill_uid = rand_uid();
			fill_uid[IDX_W-1:0] = i[IDX_W-1:0];
			send_request(OP_ADD, fill_uid, IDX_W'(i));
		end
		first_uid = uid_table[0];
		mid_uid   = uid_table[TBL_DEPTH / 2];
		send_request(OP_ADD, ~uid_table[5], '0);
		// Fullness wins over a duplicate.
		send_request(OP_ADD, first_uid, '0);
		send_request(OP_LOOKUP, uid_table[TBL_DEPTH - 1], '0);
		send_request(OP_READ, '0, IDX_W'(TBL_DEPTH - 1));
		send_request(OP_DEL, mid_uid, '0);
		send_request(OP_READ, '0, IDX_W'(TBL_DEPTH - 1));
		send_request(OP_LOOKUP, mid_uid, '0);
		send_request(OP_ADD, UID_ONES, '0);
		send_request(OP_LOOKUP, UID_ONES, '0);
		send_request(OP_DEL, uid_table[TBL_DEPTH - 1], '0);
		send_request(OP_DEL, first_uid, '0);
		send_request(OP_READ, '0, 7'd0);
		send_request(OP_LOOKUP, first_uid, '0);
		send_request(OP_DEL, first_uid, '0);
		send_request(OP_CLEAR, '0, '0);
		send_request(OP_READ, '0, 7'd0);
	endtask

	// Random mix: deletes and lookups mostly on present identifiers so that deletes hit, adds mostly new.
	task automatic test_random(input int num_items);
		int r;
		int clear_w;
		int n;
		for (n = 0; n < num_items; n++) begin
			if (n % 40 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			// Let the table grow first, then clear now and then.
			clear_w = (n < num_items / 2) ? 0 : 40;
			r = $urandom_range(0, 999);
			if (r < 380)
				send_request(OP_ADD, pick_uid(75), pick_index());
			else if (r < 560)
				send_request(OP_DEL, pick_uid(25), pick_index());
			else if (r < 740)
				send_request(OP_LOOKUP, pick_uid(40), pick_index());
			else if (r < 920)
				send_request(OP_READ, rand_uid(), pick_index());
			else if (r < 940)
				send_request(OP_W'($urandom_range(5, 7)), rand_uid(), pick_index());
			else if (r < 940 + clear_w)
				send_request(OP_CLEAR, rand_uid(), pick_index());
			else
				send_request(OP_ADD, pick_uid(90), pick_index());
		end
	endtask

	// Ends the run if it takes far longer than the slowest correct run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		op     = OP_ADD;
		uid    = '0;
		index  = '0;
		mismatch_count = 0;
		gaps_on = 1'b1;
		for (int i = 0; i < TBL_DEPTH; i++)
			uid_table[i] = UID_ONES;
		table_count = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_basic_ops();
		test_full_table();
		test_random(640);

		start <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_replies.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
